### rtl/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue checkers.
// Used by deq_checker; takes clk and rst from the enclosing scope.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, off during reset
`define DEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, off during reset
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

### rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every module of the block but deq_mem.
package deq_pkg;

  localparam int DEFAULT_DEPTH      = 64;
  localparam int DEFAULT_DATA_WIDTH = 32;
  localparam int WORD_WIDTH         = 32;
  localparam int OCC_WIDTH          = 7;

  localparam logic signed [WORD_WIDTH-1:0] EMPTY_WORD = '1;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK       = 3'd4
  } deq_mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } deq_state_t;

  typedef struct packed {
    logic [2:0]                    mode;
    logic signed [WORD_WIDTH-1:0]  push_value;
  } deq_req_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0]  popped_value;
    deq_status_t                   status;
    logic                          is_empty;
    logic signed [WORD_WIDTH-1:0]  front_value;
    logic signed [WORD_WIDTH-1:0]  back_value;
    logic [OCC_WIDTH-1:0]          occupancy;
  } deq_rsp_t;

endpackage

### rtl/double_ended_queue.sv
// Double-ended queue of signed words in a circular slot memory. A push or a
// peek goes from accept to the done state and on to the output register; a
// pop that leaves words behind passes a read state first, which takes the
// new end word from the registered read port of the slot memory. One item
// is in work at a time. The result sits in an output register, so the next
// item is accepted while a result still waits to be taken. Pops on an empty
// queue return -1 with status empty, pushes on a full queue are dropped with
// status full. No clearing pass is needed after reset.
// Depends on deq_pkg, deq_ctrl and deq_mem.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH      = DEFAULT_DEPTH,
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  deq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output deq_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic signed [DATA_WIDTH-1:0] mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic signed [DATA_WIDTH-1:0] mem_rdata;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  deq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### rtl/deq_mem.sv
// Slot store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module deq_mem #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic signed [DATA_WIDTH-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic signed [DATA_WIDTH-1:0] rdata
);

  logic signed [DATA_WIDTH-1:0] slots [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      slots[waddr] <= wdata;
    end
    if (re) begin
      rdata <= slots[raddr];
    end
  end

endmodule

### rtl/deq_ctrl.sv
// Pointer, count and end-word registers, sequencer and output register.
// Depends on deq_pkg; drives the ports of deq_mem.
module deq_ctrl import deq_pkg::*; #(
  parameter int DEPTH      = DEFAULT_DEPTH,
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  parameter int AW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  deq_req_t                     req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output deq_rsp_t                     rsp,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic signed [DATA_WIDTH-1:0] mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  logic signed [DATA_WIDTH-1:0] mem_rdata
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  deq_state_t state, state_next;
  logic [AW-1:0] front_slot, front_slot_next;
  logic [AW-1:0] back_slot, back_slot_next;
  logic [CW-1:0] held_count, held_count_next;
  // copies of the words at both ends, so results never wait on a second read
  logic signed [DATA_WIDTH-1:0] front_word, front_word_next;
  logic signed [DATA_WIDTH-1:0] back_word, back_word_next;
  logic signed [DATA_WIDTH-1:0] popped_word, popped_word_next;
  logic pop_hit, pop_hit_next;
  logic read_front, read_front_next;
  deq_status_t status, status_next;
  logic rsp_valid_next;
  deq_rsp_t rsp_next;

  logic accept, is_push, is_pop, empty, full;
  logic [AW-1:0] front_prev, front_succ, back_prev, back_succ;
  logic signed [DATA_WIDTH-1:0] word_in;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign is_push    = (req.mode == MODE_PUSH_FRONT) || (req.mode == MODE_PUSH_BACK);
  assign is_pop     = (req.mode == MODE_POP_FRONT) || (req.mode == MODE_POP_BACK);
  assign empty      = (held_count == '0);
  assign full       = (held_count == FULL_CNT);
  assign word_in    = DATA_WIDTH'(req.push_value);
  assign front_prev = (front_slot == '0) ? LAST_SLOT : front_slot - AW'(1);
  assign front_succ = (front_slot == LAST_SLOT) ? '0 : front_slot + AW'(1);
  assign back_prev  = (back_slot == '0) ? LAST_SLOT : back_slot - AW'(1);
  assign back_succ  = (back_slot == LAST_SLOT) ? '0 : back_slot + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front_slot <= '0;
      back_slot  <= '0;
      held_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      front_slot <= front_slot_next;
      back_slot  <= back_slot_next;
      held_count <= held_count_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    front_word  <= front_word_next;
    back_word   <= back_word_next;
    popped_word <= popped_word_next;
    pop_hit     <= pop_hit_next;
    read_front  <= read_front_next;
    status      <= status_next;
    rsp         <= rsp_next;
  end

  always_comb begin
    state_next       = state;
    front_slot_next  = front_slot;
    back_slot_next   = back_slot;
    held_count_next  = held_count;
    front_word_next  = front_word;
    back_word_next   = back_word;
    popped_word_next = popped_word;
    pop_hit_next     = pop_hit;
    read_front_next  = read_front;
    status_next      = status;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    mem_we           = 1'b0;
    mem_waddr        = front_slot;
    mem_wdata        = word_in;
    mem_re           = 1'b0;
    mem_raddr        = front_succ;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next  = ST_DONE;
          pop_hit_next = 1'b0;
          state_next   = S_DONE;
          if (is_push) begin
            if (full) begin
              status_next = ST_FULL;
            end else if (empty) begin
              mem_we          = 1'b1;
              mem_waddr       = front_slot;
              back_slot_next  = front_slot;
              front_word_next = word_in;
              back_word_next  = word_in;
              held_count_next = CW'(1);
            end else if (req.mode == MODE_PUSH_FRONT) begin
              mem_we          = 1'b1;
              mem_waddr       = front_prev;
              front_slot_next = front_prev;
              front_word_next = word_in;
              held_count_next = held_count + CW'(1);
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = back_succ;
              back_slot_next  = back_succ;
              back_word_next  = word_in;
              held_count_next = held_count + CW'(1);
            end
          end else if (is_pop) begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else begin
              pop_hit_next    = 1'b1;
              held_count_next = held_count - CW'(1);
              // the new end word is read from the store and captured in the read state
              if (req.mode == MODE_POP_FRONT) begin
                popped_word_next = front_word;
                if (held_count != CW'(1)) begin
                  front_slot_next = front_succ;
                  mem_re          = 1'b1;
                  mem_raddr       = front_succ;
                  read_front_next = 1'b1;
                  state_next      = S_READ;
                end
              end else begin
                popped_word_next = back_word;
                if (held_count != CW'(1)) begin
                  back_slot_next  = back_prev;
                  mem_re          = 1'b1;
                  mem_raddr       = back_prev;
                  read_front_next = 1'b0;
                  state_next      = S_READ;
                end
              end
            end
          end
        end
      end
      S_READ: begin
        if (read_front) begin
          front_word_next = mem_rdata;
        end else begin
          back_word_next = mem_rdata;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.popped_value = pop_hit ? WORD_WIDTH'(popped_word) : EMPTY_WORD;
          rsp_next.status       = status;
          rsp_next.is_empty     = empty;
          rsp_next.front_value  = empty ? EMPTY_WORD : WORD_WIDTH'(front_word);
          rsp_next.back_value   = empty ? EMPTY_WORD : WORD_WIDTH'(back_word);
          rsp_next.occupancy    = OCC_WIDTH'(held_count);
          rsp_valid_next        = 1'b1;
          state_next            = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module deq_checker import deq_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input deq_rsp_t rsp
);

  // a stalled result beat holds
  `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // one item in work at a time
  `DEQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

  `DEQ_ASSERT_NOW(a_empty_ends, rsp_valid && rsp.is_empty,
    rsp.occupancy == '0 && rsp.front_value == EMPTY_WORD && rsp.back_value == EMPTY_WORD)

  `DEQ_ASSERT_NOW(a_refused_no_pop, rsp_valid && rsp.status != ST_DONE,
    rsp.popped_value == EMPTY_WORD)

  `DEQ_ASSERT_NOW(a_empty_pop_status, rsp_valid && rsp.status == ST_EMPTY, rsp.is_empty)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

### dv/deq_result_check.sv
// Result checker for double_ended_queue: predicts each response from the request beats.
// It compares every response beat with the oldest prediction. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_result_check import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  deq_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  deq_rsp_t rsp,
  output int       fail_count,
  output int       pending_count
);

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam int IDX_W = $clog2(DEPTH);

  // Mirror of the queue contents; data width equals the 32-bit word, so no sign fixup
  logic signed [WORD_WIDTH-1:0] slot_words [DEPTH];
  logic [IDX_W-1:0]             head_idx;
  logic [IDX_W-1:0]             tail_idx;
  logic [OCC_WIDTH-1:0]         word_count;

  deq_rsp_t expected_rsp [$];

  task automatic report_field(input string label, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %h, got %h", $time, label, want_v, got_v);
      fail_count++;
    end
  endtask

  task automatic predict_deque_step(input deq_req_t beat, output deq_rsp_t res);
    res = '0;
    res.popped_value = EMPTY_WORD;
    res.status       = ST_DONE;
    case (beat.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (word_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (word_count == 0) begin
          // first word lands at the head slot, both ends point at it
          slot_words[head_idx] = beat.push_value;
          tail_idx   = head_idx;
          word_count = OCC_WIDTH'(1);
        end else if (beat.mode == MODE_PUSH_FRONT) begin
          head_idx = (head_idx == 0) ? IDX_W'(DEPTH - 1) : head_idx - 1'b1;
          slot_words[head_idx] = beat.push_value;
          word_count++;
        end else begin
          tail_idx = (tail_idx == IDX_W'(DEPTH - 1)) ? '0 : tail_idx + 1'b1;
          slot_words[tail_idx] = beat.push_value;
          word_count++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (word_count == 0) begin
          res.status = ST_EMPTY;
        end else if (beat.mode == MODE_POP_FRONT) begin
          res.popped_value = slot_words[head_idx];
          word_count--;
          if (word_count != 0)
            head_idx = (head_idx == IDX_W'(DEPTH - 1)) ? '0 : head_idx + 1'b1;
        end else begin
          res.popped_value = slot_words[tail_idx];
          word_count--;
          if (word_count != 0)
            tail_idx = (tail_idx == 0) ? IDX_W'(DEPTH - 1) : tail_idx - 1'b1;
        end
      end
      default: ; // peek and the unused codes leave the queue alone
    endcase
    res.is_empty    = (word_count == 0);
    res.front_value = (word_count == 0) ? EMPTY_WORD : slot_words[head_idx];
    res.back_value  = (word_count == 0) ? EMPTY_WORD : slot_words[tail_idx];
    res.occupancy   = word_count;
  endtask

  always @(posedge clk) begin
    deq_rsp_t want;
    deq_rsp_t next_rsp;
    if (rst) begin
      head_idx   = '0;
      tail_idx   = '0;
      word_count = '0;
      expected_rsp.delete();
      fail_count    = 0;
      pending_count <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: response beat with nothing expected, got %h", $time, rsp);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          report_field("popped_value", want.popped_value, rsp.popped_value);
          report_field("status", 32'(want.status), 32'(rsp.status));
          report_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
          report_field("front_value", want.front_value, rsp.front_value);
          report_field("back_value", want.back_value, rsp.back_value);
          report_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
        end
      end
      if (req_valid && req_ready) begin
        predict_deque_step(req, next_rsp);
        expected_rsp.push_back(next_rsp);
      end
      pending_count <= expected_rsp.size();
    end
  end

endmodule

### dv/double_ended_queue_tb.sv
// Top of the double_ended_queue testbench: clock, reset, request and response stimulus.
// Depends on deq_pkg, the double_ended_queue RTL and deq_result_check.
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int PHASE_BEATS = 383;
  localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  deq_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  deq_rsp_t rsp;

  int fail_count;
  int pending_count;
  int send_idle_pct  = 14;
  int rsp_stall_pct  = 80;

  double_ended_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  deq_result_check u_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // Valid stays high after an accept; it only drops in an idle gap or a pause
  task automatic send_beat(input deq_req_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic deq_req_t pick_beat(input int push_pct);
    deq_req_t beat;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      beat.mode = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    else if (roll < 96)
      beat.mode = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
    else
      beat.mode = 3'($urandom_range(MODE_PEEK, MODE_UNUSED_HI));
    case ($urandom_range(0, 15))
      0:       beat.push_value = 32'h7fff_ffff;
      1:       beat.push_value = 32'h8000_0000;
      2:       beat.push_value = '0;
      3:       beat.push_value = '1;
      default: beat.push_value = $urandom();
    endcase
    return beat;
  endfunction

  // Runs of fill, drain and mixed traffic so both the full and empty edges get hit
  task automatic run_phase(input int beats, input bit pause_midway);
    int sent;
    int run_len;
    int push_pct;
    sent = 0;
    while (sent < beats) begin
      case ($urandom_range(0, 2))
        0:       begin push_pct = 90; run_len = $urandom_range(70, 100); end
        1:       begin push_pct = 8;  run_len = $urandom_range(40, 90);  end
        default: begin push_pct = 48; run_len = $urandom_range(20, 60);  end
      endcase
      if (run_len > beats - sent)
        run_len = beats - sent;
      repeat (run_len) begin
        send_beat(pick_beat(push_pct));
        sent++;
      end
      if (pause_midway && sent >= beats / 2) begin
        drain_responses();
        pause_midway = 1'b0;
      end
    end
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue: refused pops, peeks, unused codes
    send_beat('{MODE_POP_FRONT, 32'h1234_5678});
    send_beat('{MODE_POP_BACK, 32'h0});
    send_beat('{MODE_PEEK, 32'hdead_beef});
    send_beat('{MODE_UNUSED_LO, 32'h0});
    send_beat('{MODE_UNUSED_HI, 32'hffff_ffff});
    // single word in and out from the other end
    send_beat('{MODE_PUSH_FRONT, 32'h7fff_ffff});
    send_beat('{MODE_POP_BACK, 32'h0});
    send_beat('{MODE_PUSH_BACK, 32'h8000_0000});
    send_beat('{MODE_PUSH_FRONT, 32'h0});
    send_beat('{MODE_PUSH_BACK, 32'hffff_ffff});
    send_beat('{MODE_PUSH_FRONT, 32'h7fff_ffff});
    send_beat('{MODE_PEEK, 32'h0});
    send_beat('{MODE_UNUSED_MID, 32'h5555_5555});
    send_beat('{MODE_POP_FRONT, 32'h0});
    send_beat('{MODE_POP_BACK, 32'h0});
    send_beat('{MODE_POP_FRONT, 32'h0});
    send_beat('{MODE_POP_FRONT, 32'h0});
    send_beat('{MODE_POP_BACK, 32'h0});
    send_beat('{MODE_PUSH_BACK, 32'h5555_5555});
    send_beat('{MODE_PUSH_BACK, 32'haaaa_aaaa});
    send_beat('{MODE_POP_FRONT, 32'h0});
    send_beat('{MODE_POP_FRONT, 32'h0});
    send_beat('{MODE_POP_FRONT, 32'h0});

    run_phase(PHASE_BEATS, 1'b0);
    drain_responses();

    send_idle_pct = 80;
    rsp_stall_pct = 14;
    run_phase(PHASE_BEATS, 1'b0);
    drain_responses();

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    run_phase(PHASE_BEATS, 1'b1);

    req_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_count != 0 && waited < 20000);
    repeat (16) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_count != 0)
        $display("%0t: %0d responses never arrived", $time, pending_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
